FILE: rtl/core/bldc_open_loop_ramp_commutator_core_defines.svh
// Assertion macros shared by the commutator RTL
`ifndef BLDC_OPEN_LOOP_RAMP_COMMUTATOR_CORE_DEFINES_SVH
`define BLDC_OPEN_LOOP_RAMP_COMMUTATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define BOLRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define BOLRC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bolrc_pkg.sv
// Types, constants and codes of the open-loop ramp commutator
package bolrc_pkg;

    localparam int ALARM_W = 64;
    localparam int DRIVE_W = 3;
    localparam int FREQ_W  = 30;
    localparam int RES_W   = 21;
    localparam int TGT_W   = 10;
    localparam int STEP_W  = 7;
    localparam int CFG_W   = 21;
    localparam int IDX_W   = 2;
    localparam int DIV_W   = 32;
    localparam int CNT_W   = $clog2(DIV_W);
    localparam int TNS_W   = 30;

    localparam logic [IDX_W-1:0] CFG_RESOLUTION = 2'd0;
    localparam logic [IDX_W-1:0] CFG_HIGH_TGT   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_LOW_TGT    = 2'd2;
    localparam logic [IDX_W-1:0] CFG_STEP       = 2'd3;

    localparam logic [RES_W-1:0]  RES_RST   = 21'd1000000;
    localparam logic [TGT_W-1:0]  HIGH_RST  = 10'd400;
    localparam logic [TGT_W-1:0]  LOW_RST   = 10'd20;
    localparam logic [STEP_W-1:0] STEP_RST  = 7'd8;
    localparam logic [DIV_W-1:0]  IV_RST    = 32'd1000000000;

    localparam logic [DIV_W-1:0] NS_PER_S   = 32'd1000000000;
    localparam logic [DIV_W-1:0] NS_PER_US  = 32'd1000;
    localparam logic [DIV_W-1:0] MS_SCALE   = 32'd1000;
    localparam logic [DIV_W-1:0] PCT_DIV    = 32'd100;
    localparam logic [DIV_W-1:0] PCT_KEEP   = 32'd95;
    localparam logic [DIV_W-1:0] SLOW_HZ    = 32'd10;
    localparam logic [1:0]       PHASE_LAST = 2'd2;

    // reciprocals: x / 100 and x / 1000 exact for any 32-bit x
    localparam logic [DIV_W-1:0] RCP_100     = 32'h51EB_851F;
    localparam int               RCP_100_SH  = 37;
    localparam logic [DIV_W-1:0] RCP_1000    = 32'h1062_4DD3;
    localparam int               RCP_1000_SH = 38;

    typedef struct packed {
        logic [RES_W-1:0]  tick_rate_hz;
        logic [TGT_W-1:0]  high_target_hz;
        logic [TGT_W-1:0]  low_target_hz;
        logic [STEP_W-1:0] accel_step;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREQ,
        S_FREQ_W,
        S_SLOW,
        S_SLOW_W,
        S_TGT,
        S_TGT_W,
        S_STEP,
        S_STEP_W,
        S_OUT,
        S_OUT_W,
        S_PUSH
    } t_state;

endpackage

FILE: rtl/core/bolrc_if.sv
// Valid/ready channel interfaces for alarm items and commutation results
interface bolrc_in_if;
    logic                          valid;
    logic                          ready;
    logic [bolrc_pkg::ALARM_W-1:0] alarm_tick;

    modport source (output valid, output alarm_tick, input ready);
    modport sink   (input valid, input alarm_tick, output ready);
endinterface

interface bolrc_out_if;
    logic                          valid;
    logic                          ready;
    logic [bolrc_pkg::ALARM_W-1:0] next_alarm;
    logic [bolrc_pkg::DRIVE_W-1:0] phase_drive;
    logic [bolrc_pkg::FREQ_W-1:0]  switch_freq_hz;

    modport source (output valid, output next_alarm, output phase_drive,
                    output switch_freq_hz, input ready);
    modport sink   (input valid, input next_alarm, input phase_drive,
                    input switch_freq_hz, output ready);
endinterface

FILE: rtl/core/bolrc_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle
module bolrc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bolrc_pkg::t_div_req i_req,
    output bolrc_pkg::t_div_rsp o_rsp
);

    logic                             r_busy;
    logic                             r_done;
    logic [bolrc_pkg::CNT_W-1:0]      r_cnt;
    logic [bolrc_pkg::DIV_W-1:0]      r_rem;
    logic [bolrc_pkg::DIV_W-1:0]      r_quo;
    logic [bolrc_pkg::DIV_W-1:0]      r_dvs;
    logic [bolrc_pkg::DIV_W:0]        rem_sh;
    logic [bolrc_pkg::DIV_W:0]        trial;

    assign rem_sh = {r_rem, r_quo[bolrc_pkg::DIV_W-1]};
    assign trial  = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == bolrc_pkg::CNT_W'(bolrc_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (!trial[bolrc_pkg::DIV_W]) begin
                r_rem <= trial[bolrc_pkg::DIV_W-1:0];
                r_quo <= {r_quo[bolrc_pkg::DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[bolrc_pkg::DIV_W-1:0];
                r_quo <= {r_quo[bolrc_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: rtl/core/bolrc_seq.sv
// Sequencer, ramp state and datapath around the shared divider
`include "bldc_open_loop_ramp_commutator_core_defines.svh"

module bolrc_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bolrc_pkg::t_cfg     i_cfg,
    bolrc_in_if.sink            i_item,
    bolrc_out_if.source         o_result
);

    bolrc_pkg::t_state r_state, n_state;
    bolrc_pkg::t_div_req div_req;
    bolrc_pkg::t_div_rsp div_rsp;

    logic [bolrc_pkg::DIV_W-1:0]   r_iv, n_iv;
    logic                          r_up, n_up;
    logic [bolrc_pkg::TGT_W-1:0]   r_rtgt, n_rtgt;
    logic [1:0]                    r_phase, n_phase;
    logic                          r_ov, n_ov;

    logic [bolrc_pkg::ALARM_W-1:0] r_alarm, n_alarm;
    logic [bolrc_pkg::DIV_W-1:0]   r_freq, n_freq;
    logic [bolrc_pkg::DIV_W-1:0]   r_cur, n_cur;
    logic [bolrc_pkg::TNS_W-1:0]   r_tgt_ns, n_tgt_ns;
    logic                          r_neg, n_neg;
    logic [bolrc_pkg::ALARM_W-1:0] r_next, n_next;
    logic [2*bolrc_pkg::DIV_W-1:0] r_prod, n_prod;
    logic [bolrc_pkg::ALARM_W-1:0] r_o_next, n_o_next;
    logic [bolrc_pkg::DRIVE_W-1:0] r_o_drive, n_o_drive;
    logic [bolrc_pkg::FREQ_W-1:0]  r_o_freq, n_o_freq;

    logic [bolrc_pkg::DIV_W-1:0]   res_ns;
    logic                          up_a;
    logic [bolrc_pkg::TGT_W-1:0]   tgt_a;
    logic [bolrc_pkg::DIV_W:0]     den_w;
    logic [bolrc_pkg::DIV_W-1:0]   den_div;
    logic [bolrc_pkg::DIV_W:0]     diff;
    logic [bolrc_pkg::DIV_W:0]     diff_abs;
    logic [bolrc_pkg::DIV_W-1:0]   fdiv;
    logic [1:0]                    idx;
    logic [bolrc_pkg::DIV_W-1:0]   rcp_k;
    logic [2*bolrc_pkg::DIV_W-1:0] prod;
    logic                          in_acc;
    logic                          push_go;
    logic                          div_wait;

    bolrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign res_ns = bolrc_pkg::DIV_W'(i_cfg.tick_rate_hz) * bolrc_pkg::MS_SCALE;

    // shared reciprocal multiply for the /100 and /1000 scalings
    assign rcp_k = (r_state == bolrc_pkg::S_OUT) ? bolrc_pkg::RCP_1000 : bolrc_pkg::RCP_100;
    assign prod  = (2*bolrc_pkg::DIV_W)'(r_iv) * (2*bolrc_pkg::DIV_W)'(rcp_k);

    always_comb begin
        up_a  = r_up;
        tgt_a = r_rtgt;
        if (r_up && r_freq >= bolrc_pkg::DIV_W'(r_rtgt)) begin
            tgt_a = i_cfg.low_target_hz;
            up_a  = 1'b0;
        end
        if (!up_a && r_freq <= bolrc_pkg::DIV_W'(tgt_a)) begin
            tgt_a = i_cfg.high_target_hz;
            up_a  = 1'b1;
        end
    end

    always_comb begin
        if (r_up) begin
            den_w = {1'b0, r_freq} + (bolrc_pkg::DIV_W + 1)'(i_cfg.accel_step);
        end else begin
            den_w = {1'b0, r_freq} - (bolrc_pkg::DIV_W + 1)'(i_cfg.accel_step);
        end
        if (den_w[bolrc_pkg::DIV_W] || den_w == '0) begin
            den_div = bolrc_pkg::DIV_W'(1);
        end else begin
            den_div = den_w[bolrc_pkg::DIV_W-1:0];
        end
        diff     = {3'b000, r_tgt_ns} - {1'b0, r_cur};
        diff_abs = diff[bolrc_pkg::DIV_W] ? (~diff + 1'b1) : diff;
        fdiv     = (r_freq == '0) ? bolrc_pkg::DIV_W'(1) : r_freq;
        idx      = (r_phase == 2'd3) ? 2'd0 : r_phase;
    end

    always_comb begin
        n_state          = r_state;
        n_iv             = r_iv;
        n_up             = r_up;
        n_rtgt           = r_rtgt;
        n_phase          = r_phase;
        n_ov             = r_ov;
        n_alarm          = r_alarm;
        n_freq           = r_freq;
        n_cur            = r_cur;
        n_tgt_ns         = r_tgt_ns;
        n_neg            = r_neg;
        n_next           = r_next;
        n_prod           = r_prod;
        n_o_next         = r_o_next;
        n_o_drive        = r_o_drive;
        n_o_freq         = r_o_freq;
        div_req.start    = 1'b0;
        div_req.dividend = r_iv;
        div_req.divisor  = bolrc_pkg::DIV_W'(1);

        if (r_ov && o_result.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            bolrc_pkg::S_IDLE: begin
                if (i_item.valid) begin
                    n_alarm = i_item.alarm_tick;
                    n_state = bolrc_pkg::S_FREQ;
                end
            end
            bolrc_pkg::S_FREQ: begin
                div_req.start    = 1'b1;
                div_req.dividend = res_ns;
                div_req.divisor  = (r_iv == '0) ? bolrc_pkg::DIV_W'(1) : r_iv;
                n_state          = bolrc_pkg::S_FREQ_W;
            end
            bolrc_pkg::S_FREQ_W: begin
                if (div_rsp.done) begin
                    n_freq  = div_rsp.quotient;
                    n_state = bolrc_pkg::S_SLOW;
                end
            end
            bolrc_pkg::S_SLOW: begin
                n_up   = up_a;
                n_rtgt = tgt_a;
                if (r_freq < bolrc_pkg::SLOW_HZ) begin
                    n_prod  = prod;
                    n_state = bolrc_pkg::S_SLOW_W;
                end else begin
                    n_cur   = r_iv;
                    n_state = bolrc_pkg::S_TGT;
                end
            end
            bolrc_pkg::S_SLOW_W: begin
                n_cur   = bolrc_pkg::DIV_W'(r_prod[2*bolrc_pkg::DIV_W-1:bolrc_pkg::RCP_100_SH])
                          * bolrc_pkg::PCT_KEEP;
                n_state = bolrc_pkg::S_TGT;
            end
            bolrc_pkg::S_TGT: begin
                div_req.start    = 1'b1;
                div_req.dividend = bolrc_pkg::NS_PER_S;
                div_req.divisor  = den_div;
                n_state          = bolrc_pkg::S_TGT_W;
            end
            bolrc_pkg::S_TGT_W: begin
                if (div_rsp.done) begin
                    n_tgt_ns = div_rsp.quotient[bolrc_pkg::TNS_W-1:0];
                    n_state  = bolrc_pkg::S_STEP;
                end
            end
            bolrc_pkg::S_STEP: begin
                n_neg            = diff[bolrc_pkg::DIV_W];
                div_req.start    = 1'b1;
                div_req.dividend = diff_abs[bolrc_pkg::DIV_W-1:0];
                div_req.divisor  = fdiv;
                n_state          = bolrc_pkg::S_STEP_W;
            end
            bolrc_pkg::S_STEP_W: begin
                if (div_rsp.done) begin
                    n_iv    = r_neg ? (r_cur - div_rsp.quotient)
                                    : (r_cur + div_rsp.quotient);
                    n_state = bolrc_pkg::S_OUT;
                end
            end
            bolrc_pkg::S_OUT: begin
                n_prod  = prod;
                n_state = bolrc_pkg::S_OUT_W;
            end
            bolrc_pkg::S_OUT_W: begin
                n_next  = r_alarm + bolrc_pkg::ALARM_W'(
                              r_prod[2*bolrc_pkg::DIV_W-1:bolrc_pkg::RCP_1000_SH]);
                n_state = bolrc_pkg::S_PUSH;
            end
            bolrc_pkg::S_PUSH: begin
                if (!r_ov || o_result.ready) begin
                    n_ov      = 1'b1;
                    n_o_next  = r_next;
                    n_o_drive = bolrc_pkg::DRIVE_W'(1) << idx;
                    n_o_freq  = (r_freq[bolrc_pkg::DIV_W-1:bolrc_pkg::FREQ_W] != '0)
                                ? '1 : r_freq[bolrc_pkg::FREQ_W-1:0];
                    n_phase   = (idx == bolrc_pkg::PHASE_LAST) ? 2'd0 : idx + 2'd1;
                    n_state   = bolrc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bolrc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bolrc_pkg::S_IDLE;
            r_iv    <= bolrc_pkg::IV_RST;
            r_up    <= 1'b1;
            r_rtgt  <= bolrc_pkg::HIGH_RST;
            r_phase <= 2'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iv    <= n_iv;
            r_up    <= n_up;
            r_rtgt  <= n_rtgt;
            r_phase <= n_phase;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alarm   <= n_alarm;
        r_freq    <= n_freq;
        r_cur     <= n_cur;
        r_tgt_ns  <= n_tgt_ns;
        r_neg     <= n_neg;
        r_next    <= n_next;
        r_prod    <= n_prod;
        r_o_next  <= n_o_next;
        r_o_drive <= n_o_drive;
        r_o_freq  <= n_o_freq;
    end

    assign i_item.ready            = (r_state == bolrc_pkg::S_IDLE);
    assign o_result.valid          = r_ov;
    assign o_result.next_alarm     = r_o_next;
    assign o_result.phase_drive    = r_o_drive;
    assign o_result.switch_freq_hz = r_o_freq;

    assign in_acc   = i_item.valid && i_item.ready;
    assign push_go  = (r_state == bolrc_pkg::S_PUSH) && (n_state == bolrc_pkg::S_IDLE);
    assign div_wait = (r_state == bolrc_pkg::S_FREQ_W) || (r_state == bolrc_pkg::S_TGT_W) ||
                      (r_state == bolrc_pkg::S_STEP_W);

    `BOLRC_ASSERT_NOW(a_accept_div_idle, in_acc, !div_rsp.busy, "beat taken while divider busy")
    `BOLRC_ASSERT_NOW(a_drive_onehot, o_result.valid, $onehot(o_result.phase_drive), "bad drive")
    `BOLRC_ASSERT_NOW(a_done_in_wait, div_rsp.done, div_wait, "divider done outside wait state")
    `BOLRC_ASSERT_NXT(a_push_valid, push_go, o_result.valid, "result lost at push")

endmodule

FILE: rtl/core/bldc_open_loop_ramp_commutator_core.sv
// Top level: configuration registers and the commutation sequencer
//
//  channel    | dir | handshake       | payload
//  -----------+-----+-----------------+--------------------------------------------
//  i_item     | in  | valid / ready   | alarm_tick[63:0]
//  o_result   | out | valid / ready   | next_alarm[63:0], phase_drive[2:0],
//             |     |                 | switch_freq_hz[29:0]
//  i_cfg_*    | in  | write enable    | i_cfg_idx[1:0], i_cfg_data[20:0]
//
// One beat runs from accept to result through three divisions on the shared 32-bit
// divider, a reciprocal multiply for the /1000 scaling (and one for /100 below 10 Hz),
// and the push. The next beat is taken the cycle after the push.
// Synchronous active-low reset clears the ramp state and loads reset registers.
// A finished result waits in the output register; the next beat is taken meanwhile.
// A held result stalls the sequencer only when a second result is ready to push.
module bldc_open_loop_ramp_commutator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bolrc_in_if.sink                      i_item,
    bolrc_out_if.source                   o_result,
    input  logic                          i_cfg_we,
    input  logic [bolrc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bolrc_pkg::CFG_W-1:0]   i_cfg_data
);

    bolrc_pkg::t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                bolrc_pkg::CFG_RESOLUTION: n_cfg.tick_rate_hz   = i_cfg_data;
                bolrc_pkg::CFG_HIGH_TGT:   n_cfg.high_target_hz = i_cfg_data[bolrc_pkg::TGT_W-1:0];
                bolrc_pkg::CFG_LOW_TGT:    n_cfg.low_target_hz  = i_cfg_data[bolrc_pkg::TGT_W-1:0];
                bolrc_pkg::CFG_STEP:       n_cfg.accel_step     = i_cfg_data[bolrc_pkg::STEP_W-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_rate_hz   <= bolrc_pkg::RES_RST;
            r_cfg.high_target_hz <= bolrc_pkg::HIGH_RST;
            r_cfg.low_target_hz  <= bolrc_pkg::LOW_RST;
            r_cfg.accel_step     <= bolrc_pkg::STEP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    bolrc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule
